@@ rtl/cbsr_pkg.sv @@
// Shared types and constants for the character buffer splice/replace block.
// No dependencies; imported by char_buffer_splice_replace.
`default_nettype none

package cbsr_pkg;

    // Default number of bytes held in each buffer.
    localparam int CAPACITY_DEF = 64;

    // Fixed widths of the item fields.
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 6;

    // At most this many bytes are emitted after a replace.
    localparam int OUT_MAX   = 64;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND_MAIN = 2'd0,
        OP_APPEND_REPL = 2'd1,
        OP_REPLACE     = 2'd2,
        OP_CLEAR_REPL  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

endpackage

`default_nettype wire

@@ rtl/char_buffer_splice_replace.sv @@
// Top level of the character buffer splice/replace block: FSM, both buffers.
// Depends on cbsr_pkg for field widths, opcodes and status codes.
`default_nettype none

// A command is taken at a clock edge where start is high and busy is low, and
// every result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall it, so each result must be captured in that cycle. Appends and
// the clear answer with a single status transfer in the cycle after the command
// and leave busy low, so one such command can be issued every cycle. A replace
// that fails its range or capacity check answers the same way. A replace that
// succeeds raises busy and works through the main buffer memory, which has one
// read and one write port, in three passes: it moves the tail, copies the
// replacement bytes into the gap (the last write-back lands before the read-out
// starts), and then reads the new sequence out at one byte per cycle, up to 64
// bytes, with o_last on the final byte; an empty result answers with a single
// status transfer instead. Its final result is shown in the same cycle as busy
// falls. Both buffers come out of reset empty; their memories hold no reset
// value and are only ever read below the current length, so no clearing pass
// is needed.
module char_buffer_splice_replace #(
    parameter int CAPACITY = cbsr_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [cbsr_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [cbsr_pkg::CHAR_W-1:0]    i_char_in,
    input  wire logic [cbsr_pkg::POS_W-1:0]     i_start_pos,
    input  wire logic [cbsr_pkg::COUNT_W-1:0]   i_remove_count,
    output logic                                o_valid,
    output logic [cbsr_pkg::STATUS_W-1:0]       o_status,
    output logic [cbsr_pkg::CHAR_W-1:0]         o_char_out,
    output logic                                o_char_valid,
    output logic [cbsr_pkg::OUT_IDX_W-1:0]      o_out_index,
    output logic                                o_last
);
    import cbsr_pkg::*;

    // Address width of a buffer, width of a length, of the pass counter, and
    // a scratch width wide enough for every length sum and difference.
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > OUT_CNT_W) ? LW : OUT_CNT_W;
    localparam int XW = ((LW > CHAR_W) ? LW : CHAR_W) + 2;

    localparam logic [LW-1:0] CAP_L     = LW'(CAPACITY);
    localparam logic [XW-1:0] CAP_X     = XW'(CAPACITY);
    localparam logic [CW-1:0] OUT_MAX_C = CW'(OUT_MAX);

    // Replace runs through the tail move, the replacement copy and the
    // read-out; each pass starts with its counter already loaded.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_COPY,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_main_len, n_main_len;
    logic [LW-1:0]         r_repl_len, n_repl_len;
    logic [CW-1:0]         r_rem, n_rem;
    logic [AW-1:0]         r_src, n_src;
    logic [AW-1:0]         r_off, n_off;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_back, n_back;
    logic [OUT_IDX_W-1:0]  r_idx, n_idx;

    // A byte read in one cycle is written back to the main buffer in the next.
    logic                  r_mv_vld, n_mv_vld;
    logic [AW-1:0]         r_mv_dst, n_mv_dst;
    logic                  r_mv_repl, n_mv_repl;

    // Registered result fields.
    logic                  r_out_stb, n_out_stb;
    t_status               r_out_status, n_out_status;
    logic                  r_out_cv, n_out_cv;
    logic [OUT_IDX_W-1:0]  r_out_idx, n_out_idx;
    logic                  r_out_last, n_out_last;

    // Buffer memories, one read port and one write port each.
    logic [CHAR_W-1:0]     r_main_mem [CAPACITY];
    logic [CHAR_W-1:0]     r_repl_mem [CAPACITY];
    logic [CHAR_W-1:0]     r_main_q;
    logic [CHAR_W-1:0]     r_repl_q;

    logic                  main_re, main_we, repl_re, repl_we, append_main;
    logic [AW-1:0]         main_raddr, main_waddr, repl_raddr;
    logic [CHAR_W-1:0]     main_wdata;

    // Range and length arithmetic for a replace, evaluated on the command.
    logic [XW-1:0]         pos_x, cnt_x, len_x, rl_x;
    logic [XW-1:0]         end_x, new_x, tail_x, src0_x, off_x;
    logic                  accept, bad_range, too_long, dir_back;

    assign accept    = start && !busy;
    assign pos_x     = XW'(i_start_pos);
    assign cnt_x     = XW'(i_remove_count);
    assign len_x     = XW'(r_main_len);
    assign rl_x      = XW'(r_repl_len);
    assign end_x     = pos_x + cnt_x;
    assign new_x     = len_x - cnt_x + rl_x;
    assign tail_x    = len_x - end_x;
    assign off_x     = rl_x - cnt_x;
    assign bad_range = end_x > len_x;
    assign too_long  = new_x > CAP_X;
    // When the sequence grows the tail moves right, so it is walked from its
    // end downward; otherwise it is walked upward. Either way every byte is
    // read before anything lands on it.
    assign dir_back  = rl_x > cnt_x;
    assign src0_x    = dir_back ? (len_x - XW'(1)) : end_x;

    always_comb begin
        n_state      = r_state;
        n_main_len   = r_main_len;
        n_repl_len   = r_repl_len;
        n_rem        = r_rem;
        n_src        = r_src;
        n_off        = r_off;
        n_pos        = r_pos;
        n_back       = r_back;
        n_idx        = r_idx;
        n_mv_vld     = 1'b0;
        n_mv_dst     = r_mv_dst;
        n_mv_repl    = r_mv_repl;
        n_out_stb    = 1'b0;
        n_out_status = r_out_status;
        n_out_cv     = r_out_cv;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        main_re      = 1'b0;
        main_raddr   = r_src;
        repl_re      = 1'b0;
        repl_raddr   = r_src;
        repl_we      = 1'b0;
        append_main  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Every command that ends here answers with one status transfer.
                    n_out_stb    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_cv     = 1'b0;
                    n_out_idx    = '0;
                    n_out_last   = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_APPEND_MAIN: begin
                            if (r_main_len < CAP_L) begin
                                append_main = 1'b1;
                                n_main_len  = r_main_len + LW'(1);
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        OP_APPEND_REPL: begin
                            if (r_repl_len < CAP_L) begin
                                repl_we    = 1'b1;
                                n_repl_len = r_repl_len + LW'(1);
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        OP_CLEAR_REPL: begin
                            n_repl_len = '0;
                        end
                        OP_REPLACE: begin
                            if (bad_range) begin
                                n_out_status = ST_RANGE;
                            end else if (too_long) begin
                                n_out_status = ST_OVER;
                            end else begin
                                n_out_stb  = 1'b0;
                                n_main_len = new_x[LW-1:0];
                                n_rem      = tail_x[CW-1:0];
                                n_src      = src0_x[AW-1:0];
                                n_off      = off_x[AW-1:0];
                                n_pos      = pos_x[AW-1:0];
                                n_back     = dir_back;
                                n_state    = S_SHIFT;
                            end
                        end
                        default: begin
                            n_out_stb = 1'b0;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                if (r_rem == '0) begin
                    // The copy pass uses the same pointer, now offset by the
                    // gap position instead of by the length change.
                    n_rem   = CW'(r_repl_len);
                    n_src   = '0;
                    n_off   = r_pos;
                    n_state = S_COPY;
                end else begin
                    main_re   = 1'b1;
                    n_mv_vld  = 1'b1;
                    n_mv_dst  = r_src + r_off;
                    n_mv_repl = 1'b0;
                    n_src     = r_back ? (r_src - AW'(1)) : (r_src + AW'(1));
                    n_rem     = r_rem - CW'(1);
                end
            end

            S_COPY: begin
                if (r_rem == '0) begin
                    n_rem   = (CW'(r_main_len) > OUT_MAX_C) ? OUT_MAX_C : CW'(r_main_len);
                    n_src   = '0;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    repl_re   = 1'b1;
                    n_mv_vld  = 1'b1;
                    n_mv_dst  = r_src + r_off;
                    n_mv_repl = 1'b1;
                    n_src     = r_src + AW'(1);
                    n_rem     = r_rem - CW'(1);
                end
            end

            S_EMIT: begin
                if (r_rem == '0) begin
                    // The replace left the sequence empty.
                    n_out_stb    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_cv     = 1'b0;
                    n_out_idx    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else if (!r_mv_vld) begin
                    // Reads wait until the last write-back has landed.
                    main_re      = 1'b1;
                    n_out_stb    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_cv     = 1'b1;
                    n_out_idx    = r_idx;
                    n_out_last   = (r_rem == CW'(1));
                    n_idx        = r_idx + OUT_IDX_W'(1);
                    n_src        = r_src + AW'(1);
                    n_rem        = r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Write-backs and main appends never meet: appends happen only when idle.
    assign main_we    = r_mv_vld || append_main;
    assign main_waddr = r_mv_vld ? r_mv_dst : r_main_len[AW-1:0];
    assign main_wdata = r_mv_vld ? (r_mv_repl ? r_repl_q : r_main_q) : i_char_in;

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            r_main_mem[main_waddr] <= main_wdata;
        end
        if (main_re) begin
            r_main_q <= r_main_mem[main_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (repl_we) begin
            r_repl_mem[r_repl_len[AW-1:0]] <= i_char_in;
        end
        if (repl_re) begin
            r_repl_q <= r_repl_mem[repl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_main_len <= '0;
            r_repl_len <= '0;
            r_mv_vld   <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_main_len <= n_main_len;
            r_repl_len <= n_repl_len;
            r_mv_vld   <= n_mv_vld;
            r_out_stb  <= n_out_stb;
        end
        r_rem        <= n_rem;
        r_src        <= n_src;
        r_off        <= n_off;
        r_pos        <= n_pos;
        r_back       <= n_back;
        r_idx        <= n_idx;
        r_mv_dst     <= n_mv_dst;
        r_mv_repl    <= n_mv_repl;
        r_out_status <= n_out_status;
        r_out_cv     <= n_out_cv;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_out_stb;
    assign o_status     = r_out_status;
    assign o_char_valid = r_out_cv;
    assign o_out_index  = r_out_idx;
    assign o_last       = r_out_last;
    // Sequence bytes come straight from the main memory's output register.
    assign o_char_out   = r_out_cv ? r_main_q : '0;

    // A pending write-back only follows a read of the move or copy pass.
    a_move_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_vld |-> (r_state == S_SHIFT || r_state == S_COPY || r_state == S_EMIT))
        else $error("write-back pending outside a replace");

    a_main_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_len <= CAP_L)
        else $error("main length beyond capacity");

    a_repl_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_repl_len <= CAP_L)
        else $error("replacement length beyond capacity");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> o_last)
        else $error("status result without last mark");

    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode != OP_REPLACE) |=> (o_valid && o_last && !busy))
        else $error("append or clear did not answer in the next cycle");

endmodule

`default_nettype wire
